### design/rsim_pkg.sv
// Shared types and constants for the range set insert/merge core.
// No dependencies; imported by every module of the core.
package rsim_pkg;

    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 3;
    localparam int MAX_RANGES_DEF = 32;

    // Input word kind (carried on tuser)
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    // Result status codes (carried on tuser)
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // One stored range, low bound in the low half
    typedef struct packed {
        logic [VALUE_W-1:0] high;
        logic [VALUE_W-1:0] low;
    } t_entry;

    // Compare flags of one stored range against the inserted number
    typedef struct packed {
        logic hi_lt;   // high < n
        logic lo_le;   // low <= n
        logic hi_adj;  // high == n - 1, n not zero
        logic lo_adj;  // low == n + 1, n not all ones
    } t_cmp;

endpackage

### design/rsim_cmp.sv
// Compare unit: checks one stored range against the number being inserted.
// Depends on rsim_pkg for t_entry and t_cmp.
module rsim_cmp import rsim_pkg::*; (
    input  logic [VALUE_W-1:0] i_value,
    input  t_entry             i_entry,
    output t_cmp               o_cmp
);

    logic [VALUE_W-1:0] w_value_m1;
    logic [VALUE_W-1:0] w_value_p1;

    // neighbors of n; ends of the number space never wrap
    assign w_value_m1 = i_value - VALUE_W'(1);
    assign w_value_p1 = i_value + VALUE_W'(1);

    assign o_cmp.hi_lt  = (i_entry.high < i_value);
    assign o_cmp.lo_le  = (i_entry.low <= i_value);
    assign o_cmp.hi_adj = (i_value != '0) && (i_entry.high == w_value_m1);
    assign o_cmp.lo_adj = (i_value != '1) && (i_entry.low == w_value_p1);

endmodule

### design/rsim_mem.sv
// Range table storage: one write port, one read port with registered data.
// Depends on rsim_pkg for t_entry. Contents are not cleared by reset.
module rsim_mem import rsim_pkg::*; #(
    parameter int DEPTH = MAX_RANGES_DEF,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/range_set_insert_merge_core.sv
// Range set insert/merge core: sorted table of disjoint ranges, one word at a time.
// Insert: scan the ranges below the number, decide, shift entries, place a new range
// and hand over the result; scanned plus shifted entries stay within MAX_RANGES.
// Read-out: each range is read from the table and handed over in turn.
// All steps share the one table read port. Reset (i_rst_n low, synchronous) empties
// the set and the output stage; the table memory is not cleared and needs no clearing pass.
module range_set_insert_merge_core import rsim_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [VALUE_W-1:0]   s_axis_tdata,   // value
    input  logic                 s_axis_tuser,   // kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*VALUE_W-1:0] m_axis_tdata,   // range_low, range_high
    output logic [STATUS_W-1:0]  m_axis_tuser,   // status
    output logic                 m_axis_tlast
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SCAN_RD  = 10'b00_0000_0010,
        S_SCAN_CMP = 10'b00_0000_0100,
        S_DECIDE   = 10'b00_0000_1000,
        S_SH_RD    = 10'b00_0001_0000,
        S_SH_WR    = 10'b00_0010_0000,
        S_INS_WR   = 10'b00_0100_0000,
        S_RO_RD    = 10'b00_1000_0000,
        S_RO_WAIT  = 10'b01_0000_0000,
        S_PUSH     = 10'b10_0000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_j, n_j;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_kind, n_kind;
    logic               r_left, n_left;
    logic               r_right, n_right;
    logic               r_present, n_present;
    logic               r_dn, n_dn;
    logic [VALUE_W-1:0] r_prev_low, n_prev_low;
    t_entry             r_cur, n_cur;
    t_status            r_res_status, n_res_status;
    t_entry             r_res_entry, n_res_entry;
    logic               r_res_last, n_res_last;

    logic               r_out_valid;
    t_status            r_out_status;
    t_entry             r_out_entry;
    logic               r_out_last;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    t_entry             w_wdata;
    logic [AW-1:0]      w_raddr;
    t_entry             w_rdata;
    t_cmp               w_cmp;
    logic               w_out_free;
    logic               w_out_load;
    logic [CW-1:0]      w_pos_m1;
    logic [CW-1:0]      w_pos_p1;
    logic [CW-1:0]      w_j_p1;
    logic [CW-1:0]      w_j_m1;

    // table and shared compare unit
    rsim_mem #(
        .DEPTH (MAX_RANGES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rsim_cmp u_cmp (
        .i_value (r_value),
        .i_entry (w_rdata),
        .o_cmp   (w_cmp)
    );

    assign w_pos_m1   = r_pos - CW'(1);
    assign w_pos_p1   = r_pos + CW'(1);
    assign w_j_p1     = r_j + CW'(1);
    assign w_j_m1     = r_j - CW'(1);
    assign w_out_free = !r_out_valid || m_axis_tready;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_j          = r_j;
        n_value      = r_value;
        n_kind       = r_kind;
        n_left       = r_left;
        n_right      = r_right;
        n_present    = r_present;
        n_dn         = r_dn;
        n_prev_low   = r_prev_low;
        n_cur        = r_cur;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_res_last   = r_res_last;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_raddr      = '0;
        w_out_load   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_value   = s_axis_tdata;
                    n_kind    = s_axis_tuser;
                    n_pos     = '0;
                    n_j       = '0;
                    n_left    = 1'b0;
                    n_right   = 1'b0;
                    n_present = 1'b0;
                    if (s_axis_tuser == KIND_READOUT) begin
                        if (r_cnt == '0) begin
                            n_res_status = ST_EMPTY;
                            n_res_entry  = '0;
                            n_res_last   = 1'b1;
                            n_state      = S_PUSH;
                        end else begin
                            n_state = S_RO_RD;
                        end
                    end else if (r_cnt == '0) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD: begin
                w_raddr = r_pos[AW-1:0];
                n_state = S_SCAN_CMP;
            end

            // step past ranges entirely below n, remember the left neighbor
            S_SCAN_CMP: begin
                if (w_cmp.hi_lt) begin
                    n_prev_low = w_rdata.low;
                    n_left     = w_cmp.hi_adj;
                    n_pos      = w_pos_p1;
                    n_state    = (w_pos_p1 == r_cnt) ? S_DECIDE : S_SCAN_RD;
                end else begin
                    n_cur     = w_rdata;
                    n_present = w_cmp.lo_le;
                    n_right   = w_cmp.lo_adj;
                    n_state   = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_res_last = 1'b1;
                if (r_present) begin
                    n_res_status = ST_PRESENT;
                    n_res_entry  = r_cur;
                    n_state      = S_PUSH;
                end else if (r_left && r_right) begin
                    // join two ranges, then close the gap
                    w_we             = 1'b1;
                    w_waddr          = w_pos_m1[AW-1:0];
                    w_wdata.low      = r_prev_low;
                    w_wdata.high     = r_cur.high;
                    n_res_status     = ST_INSERTED;
                    n_res_entry.low  = r_prev_low;
                    n_res_entry.high = r_cur.high;
                    n_cnt            = r_cnt - CW'(1);
                    n_j              = r_pos;
                    n_dn             = 1'b1;
                    n_state          = (w_pos_p1 < r_cnt) ? S_SH_RD : S_PUSH;
                end else if (r_left) begin
                    w_we             = 1'b1;
                    w_waddr          = w_pos_m1[AW-1:0];
                    w_wdata.low      = r_prev_low;
                    w_wdata.high     = r_value;
                    n_res_status     = ST_INSERTED;
                    n_res_entry.low  = r_prev_low;
                    n_res_entry.high = r_value;
                    n_state          = S_PUSH;
                end else if (r_right) begin
                    w_we             = 1'b1;
                    w_waddr          = r_pos[AW-1:0];
                    w_wdata.low      = r_value;
                    w_wdata.high     = r_cur.high;
                    n_res_status     = ST_INSERTED;
                    n_res_entry.low  = r_value;
                    n_res_entry.high = r_cur.high;
                    n_state          = S_PUSH;
                end else if (r_cnt == CW'(MAX_RANGES)) begin
                    n_res_status = ST_FULL;
                    n_res_entry  = '0;
                    n_state      = S_PUSH;
                end else begin
                    // open a new range, shifting the upper part up by one
                    n_res_status     = ST_INSERTED;
                    n_res_entry.low  = r_value;
                    n_res_entry.high = r_value;
                    n_cnt            = r_cnt + CW'(1);
                    n_j              = r_cnt;
                    n_dn             = 1'b0;
                    n_state          = (r_cnt > r_pos) ? S_SH_RD : S_INS_WR;
                end
            end

            S_SH_RD: begin
                w_raddr = r_dn ? w_j_p1[AW-1:0] : w_j_m1[AW-1:0];
                n_state = S_SH_WR;
            end

            S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j[AW-1:0];
                w_wdata = w_rdata;
                if (r_dn) begin
                    n_j     = w_j_p1;
                    n_state = (w_j_p1 < r_cnt) ? S_SH_RD : S_PUSH;
                end else begin
                    n_j     = w_j_m1;
                    n_state = (w_j_m1 == r_pos) ? S_INS_WR : S_SH_RD;
                end
            end

            S_INS_WR: begin
                w_we         = 1'b1;
                w_waddr      = r_pos[AW-1:0];
                w_wdata.low  = r_value;
                w_wdata.high = r_value;
                n_state      = S_PUSH;
            end

            S_RO_RD: begin
                w_raddr = r_j[AW-1:0];
                n_state = S_RO_WAIT;
            end

            S_RO_WAIT: begin
                n_res_status = ST_RANGE;
                n_res_entry  = w_rdata;
                n_res_last   = (w_j_p1 == r_cnt);
                n_state      = S_PUSH;
            end

            // hand the staged result to the output register
            S_PUSH: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    if (r_kind == KIND_READOUT && !r_res_last) begin
                        n_j     = w_j_p1;
                        n_state = S_RO_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_j          <= n_j;
        r_value      <= n_value;
        r_kind       <= n_kind;
        r_left       <= n_left;
        r_right      <= n_right;
        r_present    <= n_present;
        r_dn         <= n_dn;
        r_prev_low   <= n_prev_low;
        r_cur        <= n_cur;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_res_last   <= n_res_last;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_entry  <= r_res_entry;
            r_out_last   <= r_res_last;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_entry;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_RANGES))
        else $error("range count above table size");

    a_cnt_only_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DECIDE) |=> $stable(r_cnt))
        else $error("range count changed outside decide step");

    a_waddr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ({1'b0, w_waddr} < (AW+1)'(MAX_RANGES)))
        else $error("table write beyond its depth");

    a_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_RD || r_state == S_SCAN_CMP) |-> (r_pos < r_cnt))
        else $error("scan position past stored ranges");
`endif

endmodule

### bench/range_set_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the range set insert/merge core: keeps its own copy of the range
// table, predicts the result words of each accepted input word and checks the output.
// Depends on rsim_pkg for widths, kinds and status codes.
module range_set_checker import rsim_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [VALUE_W-1:0]   s_axis_tdata,   // value
    input  logic                 s_axis_tuser,   // kind
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [2*VALUE_W-1:0] m_axis_tdata,   // range_low, range_high
    input  logic [STATUS_W-1:0]  m_axis_tuser,   // status
    input  logic                 m_axis_tlast,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_full_drops
);

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] low;
        logic [VALUE_W-1:0] high;
        logic               last;
    } t_report;

    // Shadow copy of the range table
    logic [VALUE_W-1:0] set_lo [MAX_RANGES];
    logic [VALUE_W-1:0] set_hi [MAX_RANGES];
    int                 set_count;

    t_report report_q [$];
    int      mismatch_count;
    int      result_count;
    int      drop_count;

    task automatic owe_report(input t_status st, input logic [VALUE_W-1:0] lo,
                              input logic [VALUE_W-1:0] hi, input logic last);
        t_report r;
        r.status = st;
        r.low    = lo;
        r.high   = hi;
        r.last   = last;
        report_q.push_back(r);
    endtask

    // Insert one number into the shadow table
    task automatic place_number(input logic [VALUE_W-1:0] n);
        int pos;
        bit left_adj;
        bit right_adj;
        pos = 0;
        // first range whose high end reaches n
        while (pos < set_count && set_hi[pos] < n)
            pos++;
        if (pos < set_count && set_lo[pos] <= n) begin
            owe_report(ST_PRESENT, set_lo[pos], set_hi[pos], 1'b1);
            return;
        end
        // neighbors never wrap around the ends of the number space
        left_adj  = (pos > 0) && (n != '0) && (set_hi[pos-1] == n - 32'd1);
        right_adj = (pos < set_count) && (n != '1) && (set_lo[pos] == n + 32'd1);
        if (left_adj && right_adj) begin
            set_hi[pos-1] = set_hi[pos];
            for (int j = pos; j + 1 < set_count; j++) begin
                set_lo[j] = set_lo[j+1];
                set_hi[j] = set_hi[j+1];
            end
            set_count--;
            owe_report(ST_INSERTED, set_lo[pos-1], set_hi[pos-1], 1'b1);
        end else if (left_adj) begin
            set_hi[pos-1] = n;
            owe_report(ST_INSERTED, set_lo[pos-1], n, 1'b1);
        end else if (right_adj) begin
            set_lo[pos] = n;
            owe_report(ST_INSERTED, n, set_hi[pos], 1'b1);
        end else if (set_count >= MAX_RANGES) begin
            owe_report(ST_FULL, '0, '0, 1'b1);
        end else begin
            for (int j = set_count; j > pos; j--) begin
                set_lo[j] = set_lo[j-1];
                set_hi[j] = set_hi[j-1];
            end
            set_lo[pos] = n;
            set_hi[pos] = n;
            set_count++;
            owe_report(ST_INSERTED, n, n, 1'b1);
        end
    endtask

    // Read-out: every range in order, or one empty marker
    task automatic list_ranges();
        if (set_count == 0) begin
            owe_report(ST_EMPTY, '0, '0, 1'b1);
        end else begin
            for (int i = 0; i < set_count; i++)
                owe_report(ST_RANGE, set_lo[i], set_hi[i], (i + 1 == set_count));
        end
    endtask

    // Compare one output word with the oldest owed report
    task automatic check_word();
        t_report want;
        t_report got;
        got.status = t_status'(m_axis_tuser);
        got.low    = m_axis_tdata[VALUE_W-1:0];
        got.high   = m_axis_tdata[2*VALUE_W-1:VALUE_W];
        got.last   = m_axis_tlast;
        result_count++;
        if (report_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: output word with nothing owed: status %0d low %h high %h last %b",
                     $time, got.status, got.low, got.high, got.last);
            return;
        end
        want = report_q.pop_front();
        if (want.status !== got.status || want.low !== got.low ||
            want.high !== got.high || want.last !== got.last) begin
            mismatch_count++;
            $display("%0t: mismatch: expected status %0d low %h high %h last %b",
                     $time, want.status, want.low, want.high, want.last);
            $display("%0t:           actual   status %0d low %h high %h last %b",
                     $time, got.status, got.low, got.high, got.last);
        end else if (got.status == ST_FULL) begin
            drop_count++;
        end
    endtask

    // Outputs are checked before the input of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_count = 0;
            report_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == KIND_READOUT)
                    list_ranges();
                else
                    place_number(s_axis_tdata);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= report_q.size();
        o_results    <= result_count;
        o_full_drops <= drop_count;
    end

    initial begin
        set_count      = 0;
        mismatch_count = 0;
        result_count   = 0;
        drop_count     = 0;
        o_fail_count   = 0;
        o_pending      = 0;
        o_results      = 0;
        o_full_drops   = 0;
    end

endmodule

### bench/tb_range_set_insert_merge_core.sv
`timescale 1ns / 100ps
// Top of the range set insert/merge core bench: clock, reset, stimulus and verdict.
// Depends on rsim_pkg, range_set_insert_merge_core and range_set_checker.
module tb_range_set_insert_merge_core;
    import rsim_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 340;
    localparam int CALM_FROM      = 280;
    localparam int DRAIN_CYCLES   = 4 * MAX_RANGES_DEF + 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [VALUE_W-1:0]   s_axis_tdata = '0;    // value
    logic                 s_axis_tuser = KIND_INSERT; // kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [2*VALUE_W-1:0] m_axis_tdata;         // range_low, range_high
    logic [STATUS_W-1:0]  m_axis_tuser;         // status
    logic                 m_axis_tlast;

    int fail_count;
    int pending;
    int results;
    int full_drops;
    int idle_cycles = 0;
    int stall_left = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int n_inserts = 0;
    int n_readouts = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    range_set_insert_merge_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    range_set_checker #(.MAX_RANGES(MAX_RANGES_DEF)) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_full_drops  (full_drops)
    );

    // Result sink: random stall bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 10);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: cycles in a row with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL range_set_insert_merge_core");
            $finish;
        end
    end

    // Send one input word, after an optional idle burst; returns at the accepting edge
    task automatic send_word(input logic kind, input logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
            gap = $urandom_range(1, 11);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_READOUT)
            n_readouts++;
        else
            n_inserts++;
    endtask

    initial begin
        logic [VALUE_W-1:0] base;
        int width;
        int reps;
        int roll;
        int sent;
        bit descend;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ends of the number space, every way an insert resolves
        send_word(KIND_READOUT, 32'hFFFF_FFFF);   // empty table
        send_word(KIND_INSERT,  32'h0000_0000);
        send_word(KIND_INSERT,  32'h0000_0000);   // already present
        send_word(KIND_INSERT,  32'hFFFF_FFFF);
        send_word(KIND_INSERT,  32'hFFFF_FFFE);   // grows downward
        send_word(KIND_INSERT,  32'hFFFF_FFFF);   // present at top end
        send_word(KIND_INSERT,  32'h0000_0001);   // grows upward from 0
        send_word(KIND_INSERT,  32'h0000_0003);
        send_word(KIND_INSERT,  32'h0000_0002);   // joins two ranges
        send_word(KIND_INSERT,  32'h0000_0001);   // inside a range
        send_word(KIND_INSERT,  32'h8000_0000);
        send_word(KIND_INSERT,  32'h7FFF_FFFE);
        send_word(KIND_INSERT,  32'h7FFF_FFFF);   // merge across bit 31
        send_word(KIND_INSERT,  32'h5555_5555);
        send_word(KIND_INSERT,  32'hAAAA_AAAA);
        send_word(KIND_INSERT,  32'h5555_5555);
        send_word(KIND_READOUT, 32'h0000_0000);

        // Fill the table with single numbers until inserts get dropped
        base = $urandom_range(32'h1000_0000, 32'h4FFF_FFFF);
        for (int k = 0; k < 35; k++)
            send_word(KIND_INSERT, base + 2 * k);
        // growing still works when full
        send_word(KIND_INSERT, base - 1);
        send_word(KIND_INSERT, base + 53);
        send_word(KIND_READOUT, $urandom());
        // close the gaps one by one; each insert merges two ranges
        for (int k = 0; k < 26; k++)
            send_word(KIND_INSERT, base + 2 * k + 1);
        send_word(KIND_READOUT, $urandom());

        // Random phases: a value window per phase, mostly local inserts
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if (sent >= CALM_FROM) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = $urandom_range(0, 2) * 12;
                sink_idle_pct = $urandom_range(0, 2) * 12;
            end
            width = $urandom_range(6, 40);
            roll  = $urandom_range(0, 9);
            if (roll == 0)
                base = '0;
            else if (roll == 1)
                base = 32'hFFFF_FFFF - (width - 1);
            else
                base = $urandom_range(0, 32'hFFFF_FFFF - width);

            reps = $urandom_range(width / 2, width);
            for (int k = 0; k < reps; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    send_word(KIND_READOUT, $urandom());
                else if (roll < 13)
                    send_word(KIND_INSERT, $urandom());
                else
                    send_word(KIND_INSERT, base + $urandom_range(0, width - 1));
                sent++;
            end
            // usually sweep the whole window so it collapses to one range
            if ($urandom_range(0, 3) != 0) begin
                descend = $urandom_range(0, 1);
                for (int k = 0; k < width; k++) begin
                    send_word(KIND_INSERT, descend ? base + (width - 1 - k) : base + k);
                    sent++;
                end
            end
        end
        send_word(KIND_READOUT, $urandom());

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d inserts and %0d read-outs: %0d result words checked,",
                 n_inserts, n_readouts, results);
        $display("including %0d table-full drops.", full_drops);
        if (fail_count == 0 && pending == 0)
            $display("PASS range_set_insert_merge_core");
        else
            $display("FAIL range_set_insert_merge_core");
        $finish;
    end

endmodule

### sim.f
design/rsim_pkg.sv
design/rsim_cmp.sv
design/rsim_mem.sv
design/range_set_insert_merge_core.sv
bench/range_set_checker.sv
bench/tb_range_set_insert_merge_core.sv
